// File: design/oqkp_pkg.sv
// ----------------------------------------------------------------------------
// oqkp_pkg
// Shared types and codes for the ordered queue with keyed purge.
// ----------------------------------------------------------------------------
package oqkp_pkg;

  localparam int IdW   = 16;
  localparam int OpW   = 3;
  localparam int OccW  = 5;
  // input word: opcode, client_id, product_id, quantity, search_key (67 bits)
  localparam int InW   = 72;
  // output word: found, overflow, occupancy (7 bits)
  localparam int OutW  = 8;

  typedef enum logic [OpW-1:0] {
    OP_APPEND        = 3'd0,
    OP_PURGE_CLIENT  = 3'd1,
    OP_PURGE_PRODUCT = 3'd2,
    OP_QUERY_CLIENT  = 3'd3,
    OP_QUERY_PRODUCT = 3'd4
  } op_t;

  typedef struct packed {
    logic [IdW-1:0] client;
    logic [IdW-1:0] product;
    logic [IdW-1:0] quantity;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic           capture;     // latch match token and hole flag
    logic           purge;       // matched cells become holes
    logic           by_product;  // compare product id instead of client id
    logic [IdW-1:0] key;
    logic           step;        // one compaction phase and token shift
    logic           append;      // write wr_entry into the selected cell
    entry_t         wr_entry;
  } cell_ctrl_t;

  function automatic logic [OutW-1:0] pack_result(input logic found,
                                                  input logic overflow,
                                                  input logic [OccW-1:0] occ);
    pack_result = {1'b0, occ, overflow, found};
  endfunction

endpackage

// File: design/oqkp_cell.sv
// ----------------------------------------------------------------------------
// oqkp_cell
// One queue slot: holds an entry, a hole flag for compaction and a match
// token that shifts toward the head of the chain.
// ----------------------------------------------------------------------------
module oqkp_cell
  import oqkp_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       live,       // slot is below the fill count
  input  logic       wr_sel,     // slot is the tail position
  input  logic       pair_up,    // paired with the upper neighbor this phase
  input  logic       pair_down,  // paired with the lower neighbor this phase
  input  entry_t     up_entry,
  input  logic       up_hole,
  input  logic       up_token,
  input  logic       down_hole,
  output entry_t     entry,
  output logic       hole,
  output logic       token
);

  logic match;
  logic take_up;
  logic give_down;

  // key compare on the stored entry
  assign match = ctrl.by_product ? (entry.product == ctrl.key)
                                 : (entry.client == ctrl.key);

  // a hole below a kept entry trades places with it
  assign take_up   = ctrl.step && pair_up && hole && !up_hole;
  assign give_down = ctrl.step && pair_down && !hole && down_hole;

  // entry payload
  always_ff @(posedge clk) begin
    if (ctrl.append && wr_sel) begin
      entry <= ctrl.wr_entry;
    end else if (take_up) begin
      entry <= up_entry;
    end
  end

  // hole flag and match token
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      hole  <= !live || (ctrl.purge && match);
      token <= live && match;
    end else if (ctrl.step) begin
      token <= up_token;
      if (take_up) begin
        hole <= 1'b0;
      end else if (give_down) begin
        hole <= 1'b1;
      end
    end
  end

endmodule

// File: design/ordered_queue_keyed_purge_top.sv
// ----------------------------------------------------------------------------
// ordered_queue_keyed_purge_top
// Ordered queue of entries with append, keyed purge and keyed query.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata, one operation each.
//   Every input word yields one result word on m_tvalid/m_tready/m_tdata.
//   Entries live in a chain of QUEUE_DEPTH cells, head at cell 0.
// Sequencing:
//   Append and unused opcodes finish in the cycle of acceptance; the result
//   is valid in the next cycle, and the next word can be taken then if the
//   result is taken. Purge and query: the cells latch their key compare at
//   acceptance, then QUEUE_DEPTH odd/even compaction phases run while match
//   tokens shift out at the head; a purge takes each off the fill count and a query notes whether any came.
// Reset:
//   rst empties the queue and drops any pending result word.
// Stalls:
//   A result word is held until taken; a new word is accepted in the same
//   cycle the pending result is taken, never while it still waits.
// ----------------------------------------------------------------------------
module ordered_queue_keyed_purge_top
  import oqkp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // opcode[2:0], client_id[18:3], product_id[34:19], quantity[50:35],
  // search_key[66:51], zero fill [71:67]
  input  logic [InW-1:0]  s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  // found[0], overflow[1], occupancy[6:2], zero fill [7]
  output logic [OutW-1:0] m_tdata
);

  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int StepW = $clog2(QUEUE_DEPTH);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t          state;
  logic [CntW-1:0] count;
  logic [StepW-1:0] step_cnt;
  logic            found_acc;
  logic            is_purge;

  logic            in_acc;
  logic            full;
  logic            found_now;
  logic            res_load;
  logic [CntW-1:0] count_scan;
  op_t             op;
  cell_ctrl_t      ctrl;

  entry_t ent  [QUEUE_DEPTH];
  logic   hole [QUEUE_DEPTH];
  logic   tok  [QUEUE_DEPTH];

  // input decode
  assign op       = op_t'(s_tdata[2:0]);
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign in_acc   = s_tvalid && s_tready;
  assign full     = (count >= CntW'(QUEUE_DEPTH));

  // cell broadcast
  always_comb begin
    ctrl.capture    = in_acc && ((op == OP_PURGE_CLIENT) || (op == OP_PURGE_PRODUCT) ||
                                 (op == OP_QUERY_CLIENT) || (op == OP_QUERY_PRODUCT));
    ctrl.purge      = (op == OP_PURGE_CLIENT) || (op == OP_PURGE_PRODUCT);
    ctrl.by_product = (op == OP_PURGE_PRODUCT) || (op == OP_QUERY_PRODUCT);
    ctrl.key        = s_tdata[66:51];
    ctrl.step       = (state == S_SCAN);
    ctrl.append     = in_acc && (op == OP_APPEND) && !full;
    ctrl.wr_entry.client   = s_tdata[18:3];
    ctrl.wr_entry.product  = s_tdata[34:19];
    ctrl.wr_entry.quantity = s_tdata[50:35];
  end

  // chain of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   live;
    logic   wr_sel;
    logic   pair_up;
    logic   pair_down;
    entry_t up_entry;
    logic   up_hole;
    logic   up_token;
    logic   down_hole;

    assign live   = (CntW'(i) < count);
    assign wr_sel = (CntW'(i) == count);

    if (i < QUEUE_DEPTH - 1) begin : g_up
      assign pair_up  = (step_cnt[0] == 1'(i % 2));
      assign up_entry = ent[i+1];
      assign up_hole  = hole[i+1];
      assign up_token = tok[i+1];
    end else begin : g_top
      assign pair_up  = 1'b0;
      assign up_entry = ent[i];
      assign up_hole  = 1'b1;
      assign up_token = 1'b0;
    end

    if (i > 0) begin : g_down
      assign pair_down = (step_cnt[0] == 1'((i - 1) % 2));
      assign down_hole = hole[i-1];
    end else begin : g_head
      assign pair_down = 1'b0;
      assign down_hole = 1'b0;
    end

    oqkp_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .live      (live),
      .wr_sel    (wr_sel),
      .pair_up   (pair_up),
      .pair_down (pair_down),
      .up_entry  (up_entry),
      .up_hole   (up_hole),
      .up_token  (up_token),
      .down_hole (down_hole),
      .entry     (ent[i]),
      .hole      (hole[i]),
      .token     (tok[i])
    );
  end

  // token at the head of the chain during a scan
  assign found_now  = found_acc || tok[0];
  assign count_scan = (is_purge && tok[0]) ? (count - CntW'(1)) : count;

  // result word loads on an append or unused opcode, or at the last scan phase
  assign res_load = (in_acc && !ctrl.capture) ||
                    ((state == S_SCAN) && (step_cnt == StepW'(QUEUE_DEPTH - 1)));

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step_cnt  <= '0;
      found_acc <= 1'b0;
      is_purge  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (op)
              OP_APPEND: begin
                if (full) begin
                  m_tdata <= pack_result(1'b0, 1'b1, OccW'(count));
                end else begin
                  count   <= count + CntW'(1);
                  m_tdata <= pack_result(1'b0, 1'b0, OccW'(count + CntW'(1)));
                end
              end
              OP_PURGE_CLIENT, OP_PURGE_PRODUCT,
              OP_QUERY_CLIENT, OP_QUERY_PRODUCT: begin
                state     <= S_SCAN;
                step_cnt  <= '0;
                found_acc <= 1'b0;
                is_purge  <= ctrl.purge;
              end
              default: begin
                m_tdata  <= pack_result(1'b0, 1'b0, OccW'(count));
              end
            endcase
          end
        end
        S_SCAN: begin
          found_acc <= found_now;
          count     <= count_scan;
          step_cnt  <= step_cnt + StepW'(1);
          if (step_cnt == StepW'(QUEUE_DEPTH - 1)) begin
            state    <= S_IDLE;
            m_tdata  <= pack_result(found_now, 1'b0, OccW'(count_scan));
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
